// ===== rtl/assert_macros.svh =====
// assertion macros used only by cddb_disc_id among the rtl files
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("cddb assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_IMPL(label, clk, rst_n, !(cond))

`endif

// ===== rtl/cddb_pkg.sv =====
// types, widths and constants of the disc id accumulator
// no dependencies; used by every other rtl file but assert_macros.svh
package cddb_pkg;

	// field widths
	localparam int MS_W     = 24;
	localparam int FRAME_W  = 27;
	localparam int ID_W     = 32;
	localparam int SEC_W    = 21;
	localparam int SUM_W    = 13;
	localparam int TRACK_W  = 7;
	localparam int WSEC_W   = 15;   // whole seconds of one track, max 16777
	localparam int DACC_W   = 6;    // digit sum of one start second, max 55
	localparam int DIGIT_W  = 4;
	localparam int FPS_W    = 7;

	// track limit, timing and modulus constants
	localparam logic [TRACK_W-1:0] MAX_TRACKS     = 7'd99;
	localparam logic [FPS_W-1:0]   FRAMES_PER_SEC = 7'd75;
	localparam logic [SEC_W-1:0]   GAP_SECONDS    = 21'd2;
	localparam logic [8:0]         MOD_BASE       = 9'd255;

	// ms / 1000 = (ms >> 3) / 125, exact reciprocal for 21-bit operands
	localparam int                 DIV125_SHIFT = 28;
	localparam logic [21:0]        RECIP_125    = 22'((2**DIV125_SHIFT + 124) / 125);

	// v / 10 = (v >> 1) / 5, exact reciprocal for 20-bit operands
	localparam int                 DIV5_SHIFT = 22;
	localparam logic [19:0]        RECIP_5    = 20'((2**DIV5_SHIFT + 4) / 5);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// classified item as held in the queue
	typedef struct packed {
		logic [WSEC_W-1:0] secs;
		logic              last;
	} cddb_item_t;

	// back sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIGIT,
		BK_WRITE
	} bk_state_t;

endpackage

// ===== rtl/cddb_in_if.sv =====
// input channel: one track length per item
// depends on cddb_pkg for field widths
interface cddb_in_if;
	logic                         valid;
	logic                         ready;
	logic [cddb_pkg::MS_W-1:0]    track_ms;
	logic                         last_track;

	modport source (output valid, output track_ms, output last_track, input ready);
	modport sink (input valid, input track_ms, input last_track, output ready);
endinterface

// ===== rtl/cddb_out_if.sv =====
// output channel: one result per track item
// depends on cddb_pkg for field widths
interface cddb_out_if;
	logic                          valid;
	logic                          ready;
	logic [cddb_pkg::FRAME_W-1:0]  offset_frames;
	logic [cddb_pkg::ID_W-1:0]     disc_id;
	logic [cddb_pkg::SEC_W-1:0]    total_seconds;
	logic [cddb_pkg::TRACK_W-1:0]  track_total;
	logic                          is_last;
	logic                          too_many;

	modport source (output valid, output offset_frames, output disc_id,
		output total_seconds, output track_total, output is_last,
		output too_many, input ready);
	modport sink (input valid, input offset_frames, input disc_id,
		input total_seconds, input track_total, input is_last,
		input too_many, output ready);
endinterface

// ===== rtl/cddb_front.sv =====
// front part: accepts track items, turns ms into whole seconds, queues them
// depends on cddb_pkg and cddb_in_if
module cddb_front #(
	parameter int QUEUE_DEPTH = cddb_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cddb_in_if.sink               track,
	output logic                  q_valid,
	output cddb_pkg::cddb_item_t  q_item,
	input  logic                  pop
);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	cddb_pkg::cddb_item_t queue_q [QUEUE_DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic [42:0]      div_prod;
	cddb_pkg::cddb_item_t new_item;

	// whole seconds by reciprocal multiply
	assign div_prod = 43'(track.track_ms[23:3]) * 43'(cddb_pkg::RECIP_125);
	assign new_item.secs = div_prod[42:cddb_pkg::DIV125_SHIFT];
	assign new_item.last = track.last_track;

	assign track.ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push        = track.valid && track.ready;
	assign q_valid     = (count_q != '0);
	assign q_item      = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/cddb_back.sv =====
// back part: digit sum sequencer, disc state and result register
// depends on cddb_pkg and cddb_out_if
module cddb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  cddb_pkg::cddb_item_t  q_item,
	output logic                  pop,
	cddb_out_if.source            result
);
	cddb_pkg::bk_state_t state_q, state_d;

	logic [cddb_pkg::SEC_W-1:0]   start_q;
	logic [cddb_pkg::SUM_W-1:0]   dsum_q;
	logic [cddb_pkg::TRACK_W-1:0] seen_q;
	logic [cddb_pkg::WSEC_W-1:0]  secs_q;
	logic                         last_q;
	logic                         tm_q;
	logic [cddb_pkg::SEC_W-1:0]   dig_v_q;
	logic [cddb_pkg::DACC_W-1:0]  dig_acc_q;
	logic                         ov_q;

	logic [cddb_pkg::FRAME_W-1:0] offset_q;
	logic [cddb_pkg::ID_W-1:0]    id_q;
	logic [cddb_pkg::SEC_W-1:0]   total_q;
	logic [cddb_pkg::TRACK_W-1:0] count_out_q;
	logic                         is_last_q;
	logic                         too_many_q;

	logic                         out_free;
	logic                         dig_step;
	logic                         wr;
	logic                         over_limit;

	logic [39:0]                  div10_prod;
	logic [17:0]                  q10;
	logic [cddb_pkg::SEC_W-1:0]   times10;
	logic [cddb_pkg::SEC_W-1:0]   rem10;

	logic [cddb_pkg::SUM_W-1:0]   sum_new;
	logic [8:0]                   fold;
	logic [7:0]                   sum_mod;
	logic [cddb_pkg::SEC_W-1:0]   total;
	logic [27:0]                  offset_full;
	logic [cddb_pkg::TRACK_W-1:0] count;
	logic [cddb_pkg::ID_W-1:0]    id;

	assign out_free   = !ov_q || result.ready;
	assign over_limit = (seen_q >= cddb_pkg::MAX_TRACKS);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cddb_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_d = over_limit ? cddb_pkg::BK_WRITE : cddb_pkg::BK_DIGIT;
				end
			end
			cddb_pkg::BK_DIGIT: begin
				if (dig_v_q == '0) begin
					state_d = cddb_pkg::BK_WRITE;
				end
			end
			cddb_pkg::BK_WRITE: begin
				if (out_free) begin
					state_d = cddb_pkg::BK_IDLE;
				end
			end
			default: state_d = cddb_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop      = 1'b0;
		dig_step = 1'b0;
		wr       = 1'b0;
		unique case (state_q)
			cddb_pkg::BK_IDLE:  pop      = q_valid;
			cddb_pkg::BK_DIGIT: dig_step = (dig_v_q != '0);
			cddb_pkg::BK_WRITE: wr       = out_free;
			default: ;
		endcase
	end

	// one decimal digit per cycle: v / 10 by reciprocal, remainder by shifts
	assign div10_prod = 40'(dig_v_q[20:1]) * 40'(cddb_pkg::RECIP_5);
	assign q10        = div10_prod[39:cddb_pkg::DIV5_SHIFT];
	assign times10    = {q10, 3'b000} + {2'b00, q10, 1'b0};
	assign rem10      = dig_v_q - times10;

	// result fields for a counted track
	assign sum_new     = dsum_q + cddb_pkg::SUM_W'(dig_acc_q);
	assign fold        = {1'b0, sum_new[7:0]} + 9'(sum_new[12:8]);
	assign sum_mod     = (fold >= cddb_pkg::MOD_BASE) ? 8'(fold - cddb_pkg::MOD_BASE)
	                                                : fold[7:0];
	assign total       = start_q + cddb_pkg::SEC_W'(secs_q);
	assign offset_full = 28'(start_q) * 28'(cddb_pkg::FRAMES_PER_SEC);
	assign count       = seen_q + 1'b1;
	assign id          = {sum_mod, 24'd0} | {3'b000, total, 8'd0} | 32'(count);

	// sequencer and disc state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cddb_pkg::BK_IDLE;
			start_q <= cddb_pkg::GAP_SECONDS;
			dsum_q  <= '0;
			seen_q  <= '0;
		end else begin
			state_q <= state_d;
			if (wr) begin
				if (tm_q || last_q) begin
					start_q <= cddb_pkg::GAP_SECONDS;
					dsum_q  <= '0;
					seen_q  <= '0;
				end else begin
					start_q <= total + cddb_pkg::GAP_SECONDS;
					dsum_q  <= sum_new;
					seen_q  <= count;
				end
			end
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		if (pop) begin
			secs_q    <= q_item.secs;
			last_q    <= q_item.last;
			tm_q      <= over_limit;
			dig_v_q   <= start_q;
			dig_acc_q <= '0;
		end else if (dig_step) begin
			dig_v_q   <= cddb_pkg::SEC_W'(q10);
			dig_acc_q <= dig_acc_q + cddb_pkg::DACC_W'(rem10[cddb_pkg::DIGIT_W-1:0]);
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (wr) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (wr) begin
			if (tm_q) begin
				offset_q    <= '0;
				id_q        <= '0;
				total_q     <= '0;
				count_out_q <= '0;
				is_last_q   <= 1'b0;
				too_many_q  <= 1'b1;
			end else begin
				offset_q    <= offset_full[cddb_pkg::FRAME_W-1:0];
				id_q        <= last_q ? id : '0;
				total_q     <= last_q ? total : '0;
				count_out_q <= count;
				is_last_q   <= last_q;
				too_many_q  <= 1'b0;
			end
		end
	end

	assign result.valid         = ov_q;
	assign result.offset_frames = offset_q;
	assign result.disc_id       = id_q;
	assign result.total_seconds = total_q;
	assign result.track_total   = count_out_q;
	assign result.is_last       = is_last_q;
	assign result.too_many      = too_many_q;
endmodule

// ===== rtl/cddb_disc_id.sv =====
// top level of the disc id accumulator: front queue plus back sequencer
// depends on cddb_pkg, cddb_in_if, cddb_out_if, cddb_front, cddb_back, assert_macros.svh
//
//   channel   direction  payload
//   track     in         track_ms[23:0], last_track
//   result    out        offset_frames[26:0], disc_id[31:0], total_seconds[20:0],
//                        track_total[6:0], is_last, too_many
//
// in the back an item is fetched from the queue, then the start second is reduced
// one decimal digit at a time (one reciprocal multiply per digit) until the digits
// run out, then the result is written once the output register is free
// a track over the limit skips the digits; the front takes an item each cycle until
// its queue is full. reset clears control and disc state at once, no sweep.
// a stalled result waits in the output register while the queue keeps filling
`include "assert_macros.svh"

module cddb_disc_id #(
	parameter int QUEUE_DEPTH = cddb_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	cddb_in_if.sink    track,
	cddb_out_if.source result
);
	logic                 q_valid;
	logic                 pop;
	cddb_pkg::cddb_item_t q_item;
	logic                 res_other_zero;
	logic                 res_disc_fields;
	logic                 res_count_ok;

	cddb_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.track  (track),
		.q_valid(q_valid),
		.q_item (q_item),
		.pop    (pop)
	);

	cddb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_item (q_item),
		.pop    (pop),
		.result (result)
	);

	// result field checks used by the assertions
	assign res_other_zero  = (result.offset_frames == '0) && (result.disc_id == '0)
		&& (result.total_seconds == '0) && (result.track_total == '0) && !result.is_last;
	assign res_disc_fields = (result.disc_id != '0) || (result.total_seconds != '0);
	assign res_count_ok    = (result.track_total != '0)
		&& (result.track_total <= cddb_pkg::MAX_TRACKS);

	// queue is never read while empty
	`ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop |-> q_valid)

	// an over-limit result carries nothing else
	`ASSERT_IMPL(a_too_many_clear, clk, arst_n, (result.valid && result.too_many) |-> res_other_zero)

	// disc fields only on the closing result
	`ASSERT_NEVER(a_id_only_last, clk, arst_n, result.valid && !result.is_last && res_disc_fields)

	// a counted track lies within the limit
	`ASSERT_IMPL(a_count_range, clk, arst_n, (result.valid && !result.too_many) |-> res_count_ok)
endmodule
